// ===== rtl/core/c3s_pkg.sv =====
package c3s_pkg;

  // Size limits (defaults for the top-level parameters)
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COEF_W     = 7;
  localparam int unsigned PROD_W     = 15;  // 8u x 7s
  localparam int unsigned ROWSUM_W   = 17;  // three products
  localparam int unsigned SUM_W      = 19;  // three row sums
  localparam int unsigned OROW_W     = 12;
  localparam int unsigned OCOL_W     = 10;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned MASK_W     = 63;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned WIN        = 3;
  localparam int unsigned TAPS       = WIN * WIN;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

  // Result queue depth; also bounds the number of results in flight
  localparam int unsigned FIFO_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MASK   = 2'd2
  } cfg_reg_e;

  // Per-item control carried down the pipe
  typedef struct packed {
    logic              emit;
    logic              last;
    logic [OROW_W-1:0] row;
    logic [OCOL_W-1:0] col;
  } meta_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [OROW_W-1:0]       row;
    logic [OCOL_W-1:0]       col;
    logic                    last;
  } result_t;

endpackage

// ===== rtl/core/c3s_cell.sv =====
// One window tap: holds a pixel, hands it to the next column, registers its product.
module c3s_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              shift_i,
  input  logic [c3s_pkg::PIX_W-1:0]         pix_i,
  input  logic signed [c3s_pkg::COEF_W-1:0] coef_i,
  output logic [c3s_pkg::PIX_W-1:0]         pix_o,
  output logic signed [c3s_pkg::PROD_W-1:0] prod_o
);

  logic [c3s_pkg::PIX_W-1:0]            pix_q;
  logic signed [c3s_pkg::PROD_W-1:0]    prod_q;
  logic signed [c3s_pkg::PIX_W+c3s_pkg::COEF_W:0] prod_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (shift_i) begin
      pix_q <= pix_i;
    end
  end

  assign prod_full = $signed({1'b0, pix_q}) * coef_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[c3s_pkg::PROD_W-1:0];
  end

  assign pix_o  = pix_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/core/c3s_linebuf.sv =====
// Two line buffers packed side by side: {upper, lower}. Registered read.
module c3s_linebuf #(
  parameter int unsigned DEPTH = c3s_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [2*c3s_pkg::PIX_W-1:0]   rd_data_o,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [2*c3s_pkg::PIX_W-1:0]   wr_data_i
);

  logic [2*c3s_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [2*c3s_pkg::PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/c3s_fifo.sv =====
// Small result queue; head entry drives the output port.
module c3s_fifo #(
  parameter int unsigned DEPTH = c3s_pkg::FIFO_DEPTH,
  parameter int unsigned DW    = $bits(c3s_pkg::result_t),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          valid_o,
  output logic [CW-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

// ===== rtl/core/conv3x3_stream.sv =====
// Path: the pixel completing its window goes through the line read, window shift,
//   product and row sum registers, then the result queue, to the output.
// Throughput: 1 pixel per cycle; input stalls only when the 8-entry result
//   queue plus results still in the pipe would overflow.
// Reset: asynchronous, active low; counters, window and queue clear, width 640,
//   height 480, mask zero. Line buffers are not cleared and need no sweep.
module conv3x3_stream #(
  parameter int unsigned MAX_WIDTH  = c3s_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = c3s_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [c3s_pkg::PIX_W-1:0]           pixel_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [c3s_pkg::SUM_W-1:0]    sum_o,
  output logic [c3s_pkg::OROW_W-1:0]          out_row_o,
  output logic [c3s_pkg::OCOL_W-1:0]          out_col_o,
  output logic                                frame_last_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [c3s_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [c3s_pkg::MASK_W-1:0]          cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned CNT_W = $clog2(c3s_pkg::FIFO_DEPTH + 1);
  localparam int unsigned PW    = c3s_pkg::PIX_W;

  // ---------------------------------------------------------------------------
  // Registers. Width/height writes restart the frame at row 0, column 0.
  // ---------------------------------------------------------------------------
  logic [c3s_pkg::WIDTH_W-1:0]  width_q, width_d;
  logic [c3s_pkg::HEIGHT_W-1:0] height_q, height_d;
  logic [c3s_pkg::MASK_W-1:0]   mask_q, mask_d;
  logic                         cfg_xfer;
  logic                         cfg_restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    mask_d      = mask_q;
    cfg_restart = 1'b0;
    if (cfg_xfer) begin
      case (c3s_pkg::cfg_reg_e'(cfg_index_i))
        c3s_pkg::CFG_WIDTH: begin
          width_d     = cfg_data_i[c3s_pkg::WIDTH_W-1:0];
          cfg_restart = 1'b1;
        end
        c3s_pkg::CFG_HEIGHT: begin
          height_d    = cfg_data_i[c3s_pkg::HEIGHT_W-1:0];
          cfg_restart = 1'b1;
        end
        c3s_pkg::CFG_MASK: begin
          mask_d = cfg_data_i;
        end
        default: begin
          // unmapped index: write ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= c3s_pkg::WIDTH_RST;
      height_q <= c3s_pkg::HEIGHT_RST;
      mask_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      mask_q   <= mask_d;
    end
  end

  // Effective frame size, saturated to [3, MAX]
  logic [31:0] w_eff, h_eff;

  always_comb begin
    if (32'(width_q) < 32'(c3s_pkg::WIN)) begin
      w_eff = 32'(c3s_pkg::WIN);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = 32'(width_q);
    end
    if (32'(height_q) < 32'(c3s_pkg::WIN)) begin
      h_eff = 32'(c3s_pkg::WIN);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = 32'(MAX_HEIGHT);
    end else begin
      h_eff = 32'(height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept, position counters, line buffer read
  // ---------------------------------------------------------------------------
  logic              in_xfer;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              col_wrap, row_wrap;
  logic [31:0]       row_m1, col_m1;
  c3s_pkg::meta_t    meta0;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign col_wrap = (32'(col_q) + 32'd1) >= w_eff;
  assign row_wrap = (32'(row_q) + 32'd1) >= h_eff;
  assign row_m1   = 32'(row_q) - 32'd1;
  assign col_m1   = 32'(col_q) - 32'd1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_xfer) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Result is for the centre pixel, one row up and one column left
  always_comb begin
    meta0.emit = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);
    meta0.last = (32'(row_q) == h_eff - 32'd1) && (32'(col_q) == w_eff - 32'd1);
    meta0.row  = row_m1[c3s_pkg::OROW_W-1:0];
    meta0.col  = col_m1[c3s_pkg::OCOL_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line data valid; write back, shift window
  // ---------------------------------------------------------------------------
  logic                 v1_q, v2_q, v3_q, v4_q;
  c3s_pkg::meta_t       m1_q, m2_q, m3_q, m4_q;
  logic [COL_W-1:0]     col1_q;
  logic [PW-1:0]        px1_q;
  logic [2*PW-1:0]      line_rd;
  logic [PW-1:0]        line_up, line_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_xfer;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      m1_q   <= meta0;
      col1_q <= col_q;
      px1_q  <= pixel_i;
    end
    m2_q <= m1_q;
    m3_q <= m2_q;
    m4_q <= m3_q;
  end

  // Read at stage 0, write at stage 1: columns differ (width >= 3) bar a restart
  c3s_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (v1_q),
    .wr_addr_i (col1_q),
    .wr_data_i ({line_lo, px1_q})
  );

  assign line_up = line_rd[2*PW-1:PW];
  assign line_lo = line_rd[PW-1:0];

  // ---------------------------------------------------------------------------
  // Window: 3 rows of 3 cells. Newest column enters at tap 2, moves toward 0.
  // Each cell registers its product in the cycle after the shift (stage 2 -> 3).
  // ---------------------------------------------------------------------------
  logic [PW-1:0]                       row_src [c3s_pkg::WIN];
  logic [PW-1:0]                       tap_pix [c3s_pkg::TAPS];
  logic signed [c3s_pkg::PROD_W-1:0]   tap_prod [c3s_pkg::TAPS];

  assign row_src[0] = line_up;
  assign row_src[1] = line_lo;
  assign row_src[2] = px1_q;

  for (genvar r = 0; r < c3s_pkg::WIN; r++) begin : g_row
    for (genvar c = 0; c < c3s_pkg::WIN; c++) begin : g_col
      localparam int unsigned K = r * c3s_pkg::WIN + c;
      logic [PW-1:0] cell_in;
      if (c == c3s_pkg::WIN - 1) begin : g_head
        assign cell_in = row_src[r];
      end else begin : g_link
        assign cell_in = tap_pix[K + 1];
      end
      c3s_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (v1_q),
        .pix_i   (cell_in),
        .coef_i  ($signed(mask_q[c3s_pkg::COEF_W*K +: c3s_pkg::COEF_W])),
        .pix_o   (tap_pix[K]),
        .prod_o  (tap_prod[K])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 -> 4: per-row sums. Stage 4: total into result queue.
  // ---------------------------------------------------------------------------
  logic signed [c3s_pkg::ROWSUM_W-1:0] rsum_q [c3s_pkg::WIN];
  logic signed [c3s_pkg::SUM_W-1:0]    total;

  for (genvar r = 0; r < c3s_pkg::WIN; r++) begin : g_rsum
    always_ff @(posedge clk_i) begin
      rsum_q[r] <= c3s_pkg::ROWSUM_W'(tap_prod[r*c3s_pkg::WIN])
                 + c3s_pkg::ROWSUM_W'(tap_prod[r*c3s_pkg::WIN + 1])
                 + c3s_pkg::ROWSUM_W'(tap_prod[r*c3s_pkg::WIN + 2]);
    end
  end

  assign total = c3s_pkg::SUM_W'(rsum_q[0]) + c3s_pkg::SUM_W'(rsum_q[1])
               + c3s_pkg::SUM_W'(rsum_q[2]);

  // ---------------------------------------------------------------------------
  // Result queue and input credit
  // ---------------------------------------------------------------------------
  c3s_pkg::result_t res_in, res_out;
  logic             q_push, q_pop, q_valid;
  logic [CNT_W-1:0] q_count;
  logic [2:0]       in_flight;

  assign res_in.sum  = total;
  assign res_in.row  = m4_q.row;
  assign res_in.col  = m4_q.col;
  assign res_in.last = m4_q.last;
  assign q_push      = v4_q && m4_q.emit;
  assign q_pop       = q_valid && !out_stall_i;

  c3s_fifo #(
    .DEPTH (c3s_pkg::FIFO_DEPTH),
    .DW    ($bits(c3s_pkg::result_t)),
    .CW    (CNT_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (res_in),
    .pop_i   (q_pop),
    .data_o  (res_out),
    .valid_o (q_valid),
    .count_o (q_count)
  );

  // Results still in the pipe each own a queue slot
  assign in_flight = 3'(v1_q && m1_q.emit) + 3'(v2_q && m2_q.emit)
                   + 3'(v3_q && m3_q.emit) + 3'(v4_q && m4_q.emit);
  assign in_stall_o = (32'(q_count) + 32'(in_flight)) >= c3s_pkg::FIFO_DEPTH;

  assign out_valid_o  = q_valid;
  assign sum_o        = res_out.sum;
  assign out_row_o    = res_out.row;
  assign out_col_o    = res_out.col;
  assign frame_last_o = res_out.last;

endmodule

// ===== rtl/core/c3s_checker.sv =====
// Port-level checks for conv3x3_stream.
module c3s_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [c3s_pkg::SUM_W-1:0] sum_o,
  input logic [c3s_pkg::OROW_W-1:0]       out_row_o,
  input logic [c3s_pkg::OCOL_W-1:0]       out_col_o,
  input logic                             frame_last_o
);

  // A stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sum_o) && $stable(out_row_o)
                                   && $stable(out_col_o) && $stable(frame_last_o))
    else $error("result payload changed while stalled");

  // Only interior positions are reported
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_row_o != '0) && (out_col_o != '0))
    else $error("border position reported");

  // With the queue empty the pipe alone cannot exhaust the credit
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result pending");

endmodule

bind conv3x3_stream c3s_checker u_c3s_checker (.*);
